### hdl/mhpq_pkg.sv
// Shared types and codes for the max-heap priority queue.
package mhpq_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 11;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode                   opcode;
        logic signed [DATA_W-1:0]  push_value;
    } t_cmd;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  popped_value;
        logic [CNT_W-1:0]          entry_count;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD,
        S_POP_LAST,
        S_POP_LOAD,
        S_DN_L,
        S_DN_R,
        S_DN_PICK,
        S_DN_MOVE,
        S_DONE
    } t_state;

endpackage

### hdl/mhpq_ram.sv
// Heap entry store: one write port, one read port with registered read data.
module mhpq_ram
    import mhpq_pkg::*;
#(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic signed [DATA_W-1:0]  i_wr_data,
    input  logic [AW-1:0]             i_rd_addr,
    output logic signed [DATA_W-1:0]  o_rd_data
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/mhpq_cmp.sv
// Shared signed greater-than unit used by both sift directions.
module mhpq_cmp
    import mhpq_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic                     o_gt
);

    assign o_gt = (i_a > i_b);

endmodule

### hdl/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: sequencer, store and compare unit.
//
// Command channel: a command (push a signed value, or pop the maximum) is taken at a
// clock edge where start is high and busy is low. busy stays high until the result
// has been shown, so one command is in flight at a time.
// Result channel: o_strobe is high for exactly one cycle with o_result carrying the
// status, the popped value (zero unless a pop succeeded) and the entry count after
// the command. The receiver cannot stall, and the strobe is not repeated.
// Steps per command, paced by the registered store read and the shared comparator:
//   push on full or pop on empty: straight to the result.
//   push: read the parent and compare for each level climbed, stopping at the root or
//         below a parent that is not smaller.
//   pop:  read the root, then the last entry; done when the last entry leaves, else
//         sift down a level at a time: read the left child, then the right if any,
//         keep the larger, and move it up while it is larger than the moved entry.
// The next command may be issued in the cycle after the strobe.
// Reset empties the queue at once; the store needs no clearing pass because only
// entries below the count are ever read.
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int unsigned HEAP_DEPTH = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int unsigned AW = $clog2(HEAP_DEPTH);
    localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned XW = AW + 1;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_size, n_size;
    logic [AW-1:0]            r_pos, n_pos;
    logic [AW-1:0]            r_cidx, n_cidx;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic signed [DATA_W-1:0] r_cand, n_cand;
    logic signed [DATA_W-1:0] r_pop, n_pop;
    t_status                  r_status, n_status;

    logic                     w_wr_en;
    logic [AW-1:0]            w_wr_addr;
    logic signed [DATA_W-1:0] w_wr_data;
    logic [AW-1:0]            w_rd_addr;
    logic signed [DATA_W-1:0] w_rd_data;
    logic signed [DATA_W-1:0] w_cmp_a, w_cmp_b;
    logic                     w_gt;
    logic [XW-1:0]            w_child;
    logic                     w_right_ok;
    logic [CW+CNT_W-1:0]      w_cnt_ext;

    mhpq_ram #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    mhpq_cmp u_cmp (
        .i_a  (w_cmp_a),
        .i_b  (w_cmp_b),
        .o_gt (w_gt)
    );

    assign w_child    = {r_pos, 1'b1};
    assign w_right_ok = (XW'(r_cidx) + XW'(1)) < XW'(r_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_cidx   <= n_cidx;
        r_val    <= n_val;
        r_cand   <= n_cand;
        r_pop    <= n_pop;
        r_status <= n_status;
    end

    always_comb begin
        n_state   = r_state;
        n_size    = r_size;
        n_pos     = r_pos;
        n_cidx    = r_cidx;
        n_val     = r_val;
        n_cand    = r_cand;
        n_pop     = r_pop;
        n_status  = r_status;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = r_val;
        w_rd_addr = r_cidx;
        w_cmp_a   = r_cand;
        w_cmp_b   = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pop    = '0;
                    n_status = ST_DONE;
                    if (i_cmd.opcode == OP_PUSH) begin
                        if (r_size == CW'(HEAP_DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_pos   = r_size[AW-1:0];
                            n_val   = i_cmd.push_value;
                            n_size  = r_size + CW'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_size == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_size  = r_size - CW'(1);
                            n_state = S_POP_RD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_wr_en = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_rd_addr = (r_pos - AW'(1)) >> 1;
                    n_cidx    = w_rd_addr;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_cmp_a = r_val;
                w_cmp_b = w_rd_data;
                w_wr_en = 1'b1;
                if (w_gt) begin
                    w_wr_data = w_rd_data;
                    n_pos     = r_cidx;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP_RD: begin
                w_rd_addr = '0;
                n_state   = S_POP_LAST;
            end
            S_POP_LAST: begin
                n_pop     = w_rd_data;
                w_rd_addr = r_size[AW-1:0];
                n_state   = S_POP_LOAD;
            end
            S_POP_LOAD: begin
                n_val = w_rd_data;
                n_pos = '0;
                if (r_size == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_L;
                end
            end
            S_DN_L: begin
                if (w_child >= XW'(r_size)) begin
                    w_wr_en = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_rd_addr = w_child[AW-1:0];
                    n_cidx    = w_child[AW-1:0];
                    n_state   = S_DN_R;
                end
            end
            S_DN_R: begin
                n_cand = w_rd_data;
                if (w_right_ok) begin
                    w_rd_addr = r_cidx + AW'(1);
                    n_state   = S_DN_PICK;
                end else begin
                    n_state = S_DN_MOVE;
                end
            end
            S_DN_PICK: begin
                w_cmp_a = w_rd_data;
                w_cmp_b = r_cand;
                if (w_gt) begin
                    n_cand = w_rd_data;
                    n_cidx = r_cidx + AW'(1);
                end
                n_state = S_DN_MOVE;
            end
            S_DN_MOVE: begin
                w_cmp_a = r_cand;
                w_cmp_b = r_val;
                w_wr_en = 1'b1;
                if (w_gt) begin
                    w_wr_data = r_cand;
                    n_pos     = r_cidx;
                    n_state   = S_DN_L;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_cnt_ext = (CW + CNT_W)'(r_size);

    assign busy                  = (r_state != S_IDLE);
    assign o_strobe              = (r_state == S_DONE);
    assign o_result.status       = r_status;
    assign o_result.popped_value = r_pop;
    assign o_result.entry_count  = w_cnt_ext[CNT_W-1:0];

`ifndef SYNTHESIS
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= CW'(HEAP_DEPTH))
        else $error("entry count above depth");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy)
        else $error("busy held after result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_DONE)) |-> (o_result.popped_value == '0))
        else $error("failed transaction returned a value");

    a_fail_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_DONE)) |-> $stable(r_size))
        else $error("failed transaction changed the count");
`endif

endmodule

### test/max_heap_priority_queue_test.sv
// Testbench for the max-heap priority queue: directed table, random pushes and pops, fill to full.
`timescale 1ns / 1ps

module max_heap_priority_queue_test
    import mhpq_pkg::*;
();

    localparam int unsigned HEAP_DEPTH = 1024;
    localparam int          DIR_ROWS   = 25;
    localparam int          CYCLE_CAP  = 1000000;
    localparam int          DRAIN_WAIT = 60;

    typedef struct packed {
        t_opcode                  op;
        logic signed [DATA_W-1:0] value;
        bit                       known;
        t_status                  st;
        logic signed [DATA_W-1:0] pv;
        logic [CNT_W-1:0]         cnt;
    } t_dir_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    logic signed [DATA_W-1:0] heap_mem [HEAP_DEPTH];
    int                       heap_count;
    t_result                  pending_results [$];
    t_dir_row                 dir_table [DIR_ROWS];

    int sender_idle_pct;
    int cycle_count;
    int mismatch_count;
    int result_count;
    int push_count;
    int pop_count;
    int full_count;
    int empty_count;

    max_heap_priority_queue #(
        .HEAP_DEPTH(HEAP_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_result heap_apply(t_cmd c);
        t_result                  r;
        int                       pos;
        int                       parent;
        int                       child;
        logic signed [DATA_W-1:0] tmp;
        r.status       = ST_DONE;
        r.popped_value = '0;
        if (c.opcode == OP_PUSH) begin
            if (heap_count >= HEAP_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = heap_count;
                heap_mem[pos] = c.push_value;
                heap_count++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (heap_mem[pos] <= heap_mem[parent]) break;
                    tmp = heap_mem[pos];
                    heap_mem[pos] = heap_mem[parent];
                    heap_mem[parent] = tmp;
                    pos = parent;
                end
            end
        end else begin
            if (heap_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.popped_value = heap_mem[0];
                heap_count--;
                heap_mem[0] = heap_mem[heap_count];
                pos = 0;
                while (1) begin
                    child = 2 * pos + 1;
                    if (child >= heap_count) break;
                    if (child + 1 < heap_count && heap_mem[child + 1] > heap_mem[child])
                        child++;
                    if (heap_mem[child] <= heap_mem[pos]) break;
                    tmp = heap_mem[pos];
                    heap_mem[pos] = heap_mem[child];
                    heap_mem[child] = tmp;
                    pos = child;
                end
            end
        end
        r.entry_count = heap_count[CNT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(9))
            6: return $signed($urandom_range(7)) - 4;
            7: begin
                case ($urandom_range(3))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Drive one transaction; called and returns at a falling edge.
    task automatic send_cmd(input t_cmd c, input bit known, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_cmd = c;
        do @(posedge i_clk); while (busy);
        predicted = heap_apply(c);
        pending_results.push_back(known ? want : predicted);
        if (c.opcode == OP_PUSH) push_count++;
        else pop_count++;
        if (predicted.status == ST_FULL) full_count++;
        if (predicted.status == ST_EMPTY) empty_count++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_mix(input int n, input int push_pct);
        t_cmd c;
        for (int i = 0; i < n; i++) begin
            c.opcode     = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            c.push_value = rand_value();
            send_cmd(c, 1'b0, '0);
            if ($urandom_range(39) == 0) wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("max_heap_priority_queue_test NOT OK");
            $finish;
        end
        if (i_rst_n && o_strobe) begin
            result_count <= result_count + 1;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with no command outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status)
                    flag_mismatch($sformatf("status got %0d want %0d",
                        o_result.status, want.status));
                if (o_result.popped_value !== want.popped_value)
                    flag_mismatch($sformatf("popped_value got %0d want %0d",
                        o_result.popped_value, want.popped_value));
                if (o_result.entry_count !== want.entry_count)
                    flag_mismatch($sformatf("entry_count got %0d want %0d",
                        o_result.entry_count, want.entry_count));
            end
        end
    end

    initial begin
        t_cmd    c;
        t_result want;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cmd           = '0;
        heap_count      = 0;
        cycle_count     = 0;
        mismatch_count  = 0;
        result_count    = 0;
        push_count      = 0;
        pop_count       = 0;
        full_count      = 0;
        empty_count     = 0;
        sender_idle_pct = 28;

        dir_table = '{
            '{OP_POP,  32'sh00000000, 1'b1, ST_EMPTY, 32'sh00000000, 11'd0},
            '{OP_PUSH, 32'sh7FFFFFFF, 1'b1, ST_DONE,  32'sh00000000, 11'd1},
            '{OP_PUSH, 32'sh80000000, 1'b1, ST_DONE,  32'sh00000000, 11'd2},
            '{OP_PUSH, 32'sh00000000, 1'b1, ST_DONE,  32'sh00000000, 11'd3},
            '{OP_PUSH, 32'shFFFFFFFF, 1'b1, ST_DONE,  32'sh00000000, 11'd4},
            '{OP_PUSH, 32'sh00000001, 1'b1, ST_DONE,  32'sh00000000, 11'd5},
            '{OP_POP,  32'shFFFFFFFF, 1'b1, ST_DONE,  32'sh7FFFFFFF, 11'd4},
            '{OP_POP,  32'sh00000000, 1'b1, ST_DONE,  32'sh00000001, 11'd3},
            '{OP_POP,  32'shFFFFFFFF, 1'b1, ST_DONE,  32'sh00000000, 11'd2},
            '{OP_POP,  32'sh00000000, 1'b1, ST_DONE,  32'shFFFFFFFF, 11'd1},
            '{OP_POP,  32'sh55555555, 1'b1, ST_DONE,  32'sh80000000, 11'd0},
            '{OP_POP,  32'shAAAAAAAA, 1'b1, ST_EMPTY, 32'sh00000000, 11'd0},
            '{OP_PUSH, 32'sh00000005, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_PUSH, 32'sh00000005, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_PUSH, 32'sh00000007, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_PUSH, 32'sh00000005, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_PUSH, 32'sh00000007, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_PUSH, 32'sh00000005, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_POP,  32'sh00000000, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_POP,  32'sh00000000, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_POP,  32'sh00000000, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_POP,  32'sh00000000, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_POP,  32'sh00000000, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_POP,  32'sh00000000, 1'b0, ST_DONE,  32'sh00000000, 11'd0},
            '{OP_POP,  32'sh00000000, 1'b0, ST_DONE,  32'sh00000000, 11'd0}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            c.opcode          = dir_table[i].op;
            c.push_value      = dir_table[i].value;
            want.status       = dir_table[i].st;
            want.popped_value = dir_table[i].pv;
            want.entry_count  = dir_table[i].cnt;
            send_cmd(c, dir_table[i].known, want);
        end
        wait_drained();

        run_mix(300, 58);
        wait_drained();

        sender_idle_pct = 68;
        run_mix(300, 45);
        wait_drained();

        // fill to capacity back to back, hit the full case, then pop from a deep heap
        sender_idle_pct = 0;
        c.opcode = OP_PUSH;
        while (heap_count < HEAP_DEPTH) begin
            c.push_value = rand_value();
            send_cmd(c, 1'b0, '0);
        end
        for (int i = 0; i < 4; i++) begin
            c.push_value = rand_value();
            send_cmd(c, 1'b0, '0);
        end
        run_mix(100, 20);

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("covered %0d pushes and %0d pops, %0d results, %0d full and %0d empty hits",
            push_count, pop_count, result_count, full_count, empty_count);
        $display("heap reached capacity of %0d entries; %0d mismatches",
            HEAP_DEPTH, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("max_heap_priority_queue_test OK");
        end else begin
            $display("max_heap_priority_queue_test NOT OK");
        end
        $finish;
    end

endmodule
